// ===== src/qrs_pkg.sv =====
// Package: payload types, widths and root-kind codes for the quadratic root solver.
package qrs_pkg;

    localparam int COEF_W   = 24;
    localparam int VAL_W    = 32;
    localparam int DISC_W   = 50;   // |D| < 2^49, plus sign
    localparam int SQ_W     = 41;   // sqrt(|D| * 2^32) < 2^41
    localparam int NUM_W    = 43;   // -b*2^16 +/- s
    localparam int DEN_W    = 26;   // 2*a, magnitude up to 2^24
    localparam int QUO_W    = 43;   // magnitude of a quotient
    localparam int SQ_STEPS = 41;   // one root bit per stage
    localparam int DIV_STEPS = 43;  // one quotient bit per stage

    typedef enum logic [1:0] {
        KIND_TWO_REAL = 2'd0,
        KIND_REPEATED = 2'd1,
        KIND_COMPLEX  = 2'd2,
        KIND_A_ZERO   = 2'd3
    } t_kind;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
    } t_in_word;

    typedef struct packed {
        t_kind                   root_kind;
        logic signed [VAL_W-1:0] first_value;
        logic signed [VAL_W-1:0] second_value;
        logic                    overflow;
    } t_out_word;

endpackage

// ===== src/qrs_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
module qrs_div
    import qrs_pkg::*;
(
    input  logic              i_clk,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output logic [QUO_W-1:0]  o_quo
);
    logic [NUM_W-1:0] r_num [DIV_STEPS+1];
    logic [DEN_W:0]   r_rem [DIV_STEPS+1];
    logic [DEN_W-1:0] r_den [DIV_STEPS+1];
    logic [QUO_W-1:0] r_quo [DIV_STEPS+1];

    always_comb begin
        r_num[0] = i_num;
        r_rem[0] = '0;
        r_den[0] = i_den;
        r_quo[0] = '0;
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [DEN_W+1:0] n_sh;
        logic [DEN_W+1:0] n_diff;
        always_comb begin
            n_sh   = {r_rem[k], r_num[k][NUM_W-1-k]};
            n_diff = n_sh - {2'b00, r_den[k]};
        end
        always_ff @(posedge i_clk) begin
            r_num[k+1] <= r_num[k];
            r_den[k+1] <= r_den[k];
            if (!n_diff[DEN_W+1]) begin
                r_rem[k+1] <= n_diff[DEN_W:0];
                r_quo[k+1] <= {r_quo[k][QUO_W-2:0], 1'b1};
            end else begin
                r_rem[k+1] <= n_sh[DEN_W:0];
                r_quo[k+1] <= {r_quo[k][QUO_W-2:0], 1'b0};
            end
        end
    end

    assign o_quo = r_quo[DIV_STEPS];
endmodule

// ===== src/quadratic_root_solver.sv =====
// Top level: fully pipelined quadratic root solver in Q12.12 in, Q16.16 out.
//
// Usage: drive a coefficient word on i_in with start high; it is taken at that
// edge when busy is low. busy is tied low here: the pipeline takes one word in
// every cycle and never pushes back.
// Stages: 2 for the multiplies and discriminant, 41 for the square root (one
// root bit each), 1 to form numerators, 43 for the two dividers running side by
// side (one quotient bit each), 1 for sign fixup and saturation.
// Throughput: one word per cycle, set by the bit-per-stage root and divide
// pipelines.
// Results appear on o_out for exactly one cycle, marked by o_done; the receiver
// cannot stall, so nothing is held back.
// Reset (i_rst_n low, synchronous) clears every valid bit; the data registers
// carry no reset and words in flight are dropped.
// A zero a gives kind 3 with both values and the overflow flag zero.
module quadratic_root_solver
    import qrs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_in,
    output logic      o_done,
    output t_out_word o_out
);
    localparam int LATENCY = 2 + SQ_STEPS + 1 + DIV_STEPS + 1;

    // valid line
    logic [LATENCY-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], start && !busy};
        end
    end
    assign busy   = 1'b0;
    assign o_done = r_vld[LATENCY-1];

    // stage 1: products
    logic signed [2*COEF_W-1:0] r_bb, r_ac;
    logic signed [COEF_W-1:0]   r_a1, r_b1;
    always_ff @(posedge i_clk) begin
        r_bb <= i_in.coef_b * i_in.coef_b;
        r_ac <= i_in.coef_a * i_in.coef_c;
        r_a1 <= i_in.coef_a;
        r_b1 <= i_in.coef_b;
    end

    // stage 2: discriminant, sign and magnitude
    logic signed [DISC_W-1:0] n_d;
    logic [DISC_W-2:0]        r_dmag;
    logic                     r_dneg, r_dzero;
    logic signed [COEF_W-1:0] r_a2, r_b2;
    assign n_d = DISC_W'(r_bb) - (DISC_W'(r_ac) <<< 2);
    always_ff @(posedge i_clk) begin
        r_dneg  <= n_d[DISC_W-1];
        r_dzero <= (n_d == '0);
        r_dmag  <= n_d[DISC_W-1] ? (DISC_W-1)'(-n_d) : n_d[DISC_W-2:0];
        r_a2    <= r_a1;
        r_b2    <= r_b1;
    end

    // square root pipeline: one root bit per stage over |D| * 2^32
    localparam int RAD_W = 2 * SQ_STEPS;
    localparam int REM_W = SQ_W + 2;
    logic [RAD_W-1:0]        r_rad [SQ_STEPS+1];
    logic [REM_W-1:0]        r_rem [SQ_STEPS+1];
    logic [SQ_W-1:0]         r_root[SQ_STEPS+1];
    logic signed [COEF_W-1:0] r_sa [SQ_STEPS+1];
    logic signed [COEF_W-1:0] r_sb [SQ_STEPS+1];
    logic [1:0]              r_sk [SQ_STEPS+1];
    always_comb begin
        r_rad[0]  = {1'b0, r_dmag, 32'd0};
        r_rem[0]  = '0;
        r_root[0] = '0;
        r_sa[0]   = r_a2;
        r_sb[0]   = r_b2;
        r_sk[0]   = r_dneg ? KIND_COMPLEX : (r_dzero ? KIND_REPEATED : KIND_TWO_REAL);
    end
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
        logic [REM_W-1:0] n_rem, n_trial;
        always_comb begin
            n_rem   = {r_rem[k][REM_W-3:0], r_rad[k][RAD_W-1-2*k -: 2]};
            n_trial = {r_root[k], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            r_rad[k+1] <= r_rad[k];
            r_sa[k+1]  <= r_sa[k];
            r_sb[k+1]  <= r_sb[k];
            r_sk[k+1]  <= r_sk[k];
            if (n_rem >= n_trial) begin
                r_rem[k+1]  <= n_rem - n_trial;
                r_root[k+1] <= {r_root[k][SQ_W-2:0], 1'b1};
            end else begin
                r_rem[k+1]  <= n_rem;
                r_root[k+1] <= {r_root[k][SQ_W-2:0], 1'b0};
            end
        end
    end

    // numerator stage: signed numerators as magnitudes with result signs
    logic signed [NUM_W-1:0] n_nb, n_s, n_n1, n_n2;
    logic [NUM_W-1:0]        r_m1, r_m2;
    logic                    r_ng1, r_ng2;
    logic [DEN_W-1:0]        r_den;
    logic [1:0]              r_k3;
    logic                    r_az3;
    logic                    n_aneg;
    always_comb begin
        n_nb   = -(NUM_W'(r_sb[SQ_STEPS]) <<< 16);
        n_s    = NUM_W'(r_root[SQ_STEPS]);
        n_aneg = r_sa[SQ_STEPS][COEF_W-1];
        unique case (r_sk[SQ_STEPS])
            KIND_TWO_REAL: begin n_n1 = n_nb + n_s; n_n2 = n_nb - n_s; end
            KIND_REPEATED: begin n_n1 = n_nb;       n_n2 = n_nb;       end
            default:       begin n_n1 = n_nb;       n_n2 = n_s;        end
        endcase
    end
    always_ff @(posedge i_clk) begin
        r_m1  <= n_n1[NUM_W-1] ? -n_n1 : n_n1;
        r_m2  <= n_n2[NUM_W-1] ? -n_n2 : n_n2;
        r_ng1 <= n_n1[NUM_W-1] ^ n_aneg;
        // complex imaginary part divides by |2a|, so it keeps its own sign
        r_ng2 <= (r_sk[SQ_STEPS] == KIND_COMPLEX) ? n_n2[NUM_W-1]
                                                  : (n_n2[NUM_W-1] ^ n_aneg);
        r_den <= n_aneg ? DEN_W'(-(DEN_W'(r_sa[SQ_STEPS]) <<< 1))
                        : DEN_W'(DEN_W'(r_sa[SQ_STEPS]) <<< 1);
        r_k3  <= r_sk[SQ_STEPS];
        r_az3 <= (r_sa[SQ_STEPS] == '0);
    end

    // two dividers side by side, with control carried alongside
    logic [QUO_W-1:0] w_q1, w_q2;
    logic [DEN_W-1:0] w_den_safe;
    assign w_den_safe = r_az3 ? DEN_W'(1) : r_den;
    qrs_div u_div1 (.i_clk(i_clk), .i_num(r_m1), .i_den(w_den_safe), .o_quo(w_q1));
    qrs_div u_div2 (.i_clk(i_clk), .i_num(r_m2), .i_den(w_den_safe), .o_quo(w_q2));

    logic [3:0] r_ctl [DIV_STEPS+1];   // {neg1, neg2, kind}
    logic       r_azd [DIV_STEPS+1];
    always_comb begin
        r_ctl[0] = {r_ng1, r_ng2, r_k3};
        r_azd[0] = r_az3;
    end
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_ctl
        always_ff @(posedge i_clk) begin
            r_ctl[k+1] <= r_ctl[k];
            r_azd[k+1] <= r_azd[k];
        end
    end

    // final stage: apply sign, saturate to Q16.16
    logic signed [QUO_W:0] n_s1, n_s2;
    logic [VAL_W-1:0]      n_v1, n_v2;
    logic                  n_o1, n_o2;
    localparam logic signed [QUO_W:0] VMAX = (QUO_W+1)'(32'sh7FFF_FFFF);
    localparam logic signed [QUO_W:0] VMIN = -(QUO_W+1)'(64'sh8000_0000);
    always_comb begin
        n_s1 = r_ctl[DIV_STEPS][3] ? -$signed({1'b0, w_q1}) : $signed({1'b0, w_q1});
        n_s2 = r_ctl[DIV_STEPS][2] ? -$signed({1'b0, w_q2}) : $signed({1'b0, w_q2});
        n_o1 = (n_s1 > VMAX) || (n_s1 < VMIN);
        n_o2 = (n_s2 > VMAX) || (n_s2 < VMIN);
        n_v1 = (n_s1 > VMAX) ? 32'h7FFF_FFFF : (n_s1 < VMIN) ? 32'h8000_0000 : n_s1[VAL_W-1:0];
        n_v2 = (n_s2 > VMAX) ? 32'h7FFF_FFFF : (n_s2 < VMIN) ? 32'h8000_0000 : n_s2[VAL_W-1:0];
    end
    always_ff @(posedge i_clk) begin
        if (r_azd[DIV_STEPS]) begin
            o_out.root_kind    <= KIND_A_ZERO;
            o_out.first_value  <= '0;
            o_out.second_value <= '0;
            o_out.overflow     <= 1'b0;
        end else begin
            o_out.root_kind    <= t_kind'(r_ctl[DIV_STEPS][1:0]);
            o_out.first_value  <= n_v1;
            o_out.second_value <= n_v2;
            o_out.overflow     <= n_o1 || n_o2;
        end
    end
endmodule

// ===== tb/tb_quadratic_root_solver.sv =====
// Testbench for the quadratic root solver: random and directed coefficient words, scoreboard check.
`timescale 1ns / 100ps

class root_scoreboard;
    qrs_pkg::t_out_word pending_roots[$];
    int errors;

    // integer square root of d * 2^32, truncated
    static function longint unsigned sqrt_scaled(longint unsigned d);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned pair;
        longint unsigned trial;
        rem = 0;
        root = 0;
        for (int i = 41; i >= 0; i--) begin
            pair = (i >= 16) ? ((d >> (2 * (i - 16))) & 64'd3) : 64'd0;
            rem = (rem << 2) | pair;
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    static function logic [31:0] clamp_q16(longint q, ref logic ovf);
        if (q > 64'sd2147483647) begin
            ovf = 1'b1;
            return 32'h7fffffff;
        end
        if (q < -64'sd2147483648) begin
            ovf = 1'b1;
            return 32'h80000000;
        end
        return q[31:0];
    endfunction

    function void note_coefs(qrs_pkg::t_in_word w);
        qrs_pkg::t_out_word r;
        longint ra, rb, rc, rd, den, nb, s, q1, q2;
        logic ovf;
        ra = w.coef_a;
        rb = w.coef_b;
        rc = w.coef_c;
        ovf = 1'b0;
        r = '0;
        if (ra == 0) begin
            r.root_kind = qrs_pkg::KIND_A_ZERO;
        end else begin
            rd = rb * rb - 4 * ra * rc;
            den = 2 * ra;
            nb = -rb * 65536;
            if (rd > 0) begin
                s = sqrt_scaled(rd);
                r.root_kind = qrs_pkg::KIND_TWO_REAL;
                q1 = (nb + s) / den;
                q2 = (nb - s) / den;
            end else if (rd == 0) begin
                r.root_kind = qrs_pkg::KIND_REPEATED;
                q1 = nb / den;
                q2 = q1;
            end else begin
                s = sqrt_scaled(-rd);
                r.root_kind = qrs_pkg::KIND_COMPLEX;
                q1 = nb / den;
                q2 = s / (den < 0 ? -den : den);
            end
            r.first_value = clamp_q16(q1, ovf);
            r.second_value = clamp_q16(q2, ovf);
            r.overflow = ovf;
        end
        pending_roots.push_back(r);
    endfunction

    function void check_roots(qrs_pkg::t_out_word got);
        qrs_pkg::t_out_word exp_w;
        if (pending_roots.size() == 0) begin
            report_mismatch("result word with nothing pending");
            return;
        end
        exp_w = pending_roots.pop_front();
        if (got.root_kind !== exp_w.root_kind)
            report_mismatch($sformatf("root_kind %0d, want %0d", got.root_kind,
                exp_w.root_kind));
        if (got.first_value !== exp_w.first_value)
            report_mismatch($sformatf("first_value %0d, want %0d", got.first_value,
                exp_w.first_value));
        if (got.second_value !== exp_w.second_value)
            report_mismatch($sformatf("second_value %0d, want %0d", got.second_value,
                exp_w.second_value));
        if (got.overflow !== exp_w.overflow)
            report_mismatch($sformatf("overflow %0b, want %0b", got.overflow,
                exp_w.overflow));
    endfunction

    function void report_mismatch(string msg);
        errors++;
        $display("MISMATCH: %s", msg);
    endfunction
endclass

module tb_quadratic_root_solver;
    import qrs_pkg::*;

    localparam int LATENCY   = 88;
    localparam int N_RANDOM  = 1400;
    localparam int MAX_CYCLE = 400000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_word  i_in = '0;
    logic      o_done;
    t_out_word o_out;

    root_scoreboard roots_sb = new();
    int cycle_count = 0;

    quadratic_root_solver dut (.*);

    always #4 i_clk = ~i_clk;

    // Check every strobed result word at the edge that accepts it.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_done) roots_sb.check_roots(o_out);
        if (i_rst_n && start && !busy) roots_sb.note_coefs(i_in);
        if (cycle_count > MAX_CYCLE) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones, and plenty of back-to-back words.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(30, 4);
    endfunction

    // Hold one word with start high until the block takes it.
    task automatic send_coefs(logic signed [23:0] a, logic signed [23:0] b,
                              logic signed [23:0] c, int gap);
        t_in_word w;
        w.coef_a = a;
        w.coef_b = b;
        w.coef_c = c;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in  <= w;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Coefficient with a random magnitude class so small values dominate.
    function automatic logic signed [23:0] pick_coef();
        case ($urandom_range(5))
            0: return $signed(24'($urandom()));
            1: return $signed(24'($urandom_range(8191))) - 24'sd4096;
            2: return $signed(24'($urandom_range(131071))) - 24'sd65536;
            3: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
            default: return $signed(24'($urandom_range(32767))) - 24'sd16384;
        endcase
    endfunction

    initial begin
        logic signed [23:0] a, b, c;
        int waited;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes, every root kind, degenerate a, saturation.
        send_coefs(24'sd0, 24'sd4096, 24'sd4096, 0);           // a is zero
        send_coefs(24'sd0, 24'sh800000, 24'sh7fffff, 0);
        send_coefs(24'sd4096, 24'sd0, -24'sd4096, 0);          // roots +1, -1
        send_coefs(24'sd4096, -24'sd8192, 24'sd4096, 0);       // repeated root 1
        send_coefs(24'sd4096, 24'sd0, 24'sd4096, 1);           // complex +-i
        send_coefs(-24'sd4096, 24'sd0, -24'sd4096, 0);         // complex, negative a
        send_coefs(24'sd1, 24'sh7fffff, 24'sd0, 0);            // huge root, saturates
        send_coefs(24'sd1, 24'sh800000, 24'sd0, 0);
        send_coefs(-24'sd1, 24'sh800000, 24'sh7fffff, 2);
        send_coefs(24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 0);
        send_coefs(24'sh800000, 24'sh800000, 24'sh800000, 0);
        send_coefs(24'sh800000, 24'sh7fffff, 24'sh7fffff, 0);  // near-widest discriminant
        send_coefs(24'sh7fffff, 24'sh800000, 24'sh800000, 0);
        send_coefs(24'sd1, 24'sd0, 24'sd0, 0);                 // repeated at zero
        send_coefs(24'sd1, 24'sd2, 24'sd1, 0);
        send_coefs(-24'sd1, 24'sd1, 24'sh7fffff, 0);
        send_coefs(24'sd1, 24'sd1, 24'sh7fffff, 0);            // complex, big imag
        send_coefs(24'shffffff, 24'sd0, 24'sd0, 0);

        for (int i = 0; i < N_RANDOM; i++) begin
            a = pick_coef();
            c = pick_coef();
            if ($urandom_range(9) == 0) begin
                // force a repeated root: b*b == 4ac with a = k^2, c = m^2
                a = $signed(24'($urandom_range(63, 1)));
                c = $signed(24'($urandom_range(63)));
                b = 24'(2 * a * c);
                a = a * a;
                c = c * c;
                if ($urandom_range(1)) begin
                    a = -a;
                    c = -c;
                end
            end else begin
                b = pick_coef();
            end
            if ($urandom_range(19) == 0) a = 24'sd0;
            send_coefs(a, b, c, pick_gap());
        end
        start <= 1'b0;

        waited = 0;
        while (roots_sb.pending_roots.size() != 0 && waited < 10 * LATENCY) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (LATENCY) @(negedge i_clk);
        if (roots_sb.errors == 0 && roots_sb.pending_roots.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
